/* rtl/core/bcf_pkg.sv */
// Shared types and constants for the biconnected components finder.
// Depends on nothing; every other file of the block but bcf_ram imports it.
package bcf_pkg;

    localparam int NV = 16;               // vertex capacity
    localparam int NE = 32;               // edge capacity
    localparam int VW = $clog2(NV);       // vertex id width
    localparam int SW = $clog2(NV) + 1;   // discovery stamp / parent width
    localparam int EW = $clog2(NE) + 1;   // edge count width
    localparam int CW = $clog2(NE);       // component index width

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_RUN = 2'd1;
    localparam logic [1:0] REQ_CLR = 2'd2;

    localparam logic [1:0] KIND_EDGE = 2'd0;
    localparam logic [1:0] KIND_CUT  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [SW-1:0] NO_PARENT = SW'(NV);

    typedef struct packed {
        logic [SW-1:0] disc;
        logic [SW-1:0] low;
        logic [SW-1:0] par;
    } t_vtx;

    typedef struct packed {
        logic [VW-1:0] vtx;
        logic [SW-1:0] nxt;
    } t_frame;

    typedef struct packed {
        logic [VW-1:0] from;
        logic [VW-1:0] to;
    } t_edge;

endpackage

/* rtl/core/bcf_req_if.sv */
// Request channel of the biconnected components finder.
// Depends on bcf_pkg.
interface bcf_req_if import bcf_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [1:0]    req_type;
    logic [VW-1:0] vertex_a;
    logic [VW-1:0] vertex_b;

    modport source (output valid, req_type, vertex_a, vertex_b, input ready);
    modport sink   (input valid, req_type, vertex_a, vertex_b, output ready);
endinterface

/* rtl/core/bcf_res_if.sv */
// Result channel of the biconnected components finder.
// Depends on bcf_pkg.
interface bcf_res_if import bcf_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [1:0]    kind;
    logic [CW-1:0] component_index;
    logic [VW-1:0] edge_from;
    logic [VW-1:0] edge_to;
    logic [VW-1:0] cut_vertex;
    logic [EW-1:0] component_count;
    logic          biconnected;
    logic          overflow;
    logic          last;

    modport source (output valid, kind, component_index, edge_from, edge_to, cut_vertex,
                    component_count, biconnected, overflow, last, input ready);
    modport sink   (input valid, kind, component_index, edge_from, edge_to, cut_vertex,
                    component_count, biconnected, overflow, last, output ready);
endinterface

/* rtl/core/bcf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module bcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/bcf_engine.sv */
// Sequencer for graph loading and the depth-first biconnected search, with output register.
// Depends on bcf_pkg, bcf_req_if and bcf_res_if; drives the four RAMs in the top level.
module bcf_engine import bcf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bcf_req_if.sink           i_req,
    bcf_res_if.source         o_res,
    // adjacency rows
    output logic              o_adj_we,
    output logic [VW-1:0]     o_adj_waddr,
    output logic [NV-1:0]     o_adj_wdata,
    output logic              o_adj_re,
    output logic [VW-1:0]     o_adj_raddr,
    input  logic [NV-1:0]     i_adj_rdata,
    // per-vertex search state
    output logic              o_vtx_we,
    output logic [VW-1:0]     o_vtx_waddr,
    output t_vtx              o_vtx_wdata,
    output logic              o_vtx_re,
    output logic [VW-1:0]     o_vtx_raddr,
    input  t_vtx              i_vtx_rdata,
    // search frames
    output logic              o_frm_we,
    output logic [VW-1:0]     o_frm_waddr,
    output t_frame            o_frm_wdata,
    output logic              o_frm_re,
    output logic [VW-1:0]     o_frm_raddr,
    input  t_frame            i_frm_rdata,
    // edge stack
    output logic              o_stk_we,
    output logic [CW-1:0]     o_stk_waddr,
    output t_edge             o_stk_wdata,
    output logic              o_stk_re,
    output logic [CW-1:0]     o_stk_raddr,
    input  t_edge             i_stk_rdata
);
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_CLR      = 5'd1;
    localparam logic [4:0] S_ADD1     = 5'd2;
    localparam logic [4:0] S_ADD2     = 5'd3;
    localparam logic [4:0] S_ADD3     = 5'd4;
    localparam logic [4:0] S_ADD4     = 5'd5;
    localparam logic [4:0] S_SCLR     = 5'd6;
    localparam logic [4:0] S_ROOT     = 5'd7;
    localparam logic [4:0] S_ROOT_CHK = 5'd8;
    localparam logic [4:0] S_LOADROW  = 5'd9;
    localparam logic [4:0] S_ROW      = 5'd10;
    localparam logic [4:0] S_SCAN     = 5'd11;
    localparam logic [4:0] S_NB       = 5'd12;
    localparam logic [4:0] S_DESC     = 5'd13;
    localparam logic [4:0] S_RET      = 5'd14;
    localparam logic [4:0] S_RET1     = 5'd15;
    localparam logic [4:0] S_RET2     = 5'd16;
    localparam logic [4:0] S_POP      = 5'd17;
    localparam logic [4:0] S_POPW     = 5'd18;
    localparam logic [4:0] S_CUT      = 5'd19;
    localparam logic [4:0] S_DONE     = 5'd20;

    logic [4:0]    r_state;
    logic [VW:0]   r_cnt;
    logic [VW-1:0] r_a, r_b;
    logic [NV-1:0] r_present;
    logic [EW-1:0] r_etotal;
    logic          r_ovf;
    logic [NV-1:0] r_cut;
    logic [SW-1:0] r_clk_st;
    logic [VW:0]   r_root;
    logic [VW-1:0] r_v, r_w, r_child;
    logic [SW-1:0] r_vdisc, r_vlow, r_vpar, r_next, r_clow;
    logic [NV-1:0] r_row;
    logic [VW:0]   r_depth;
    logic [1:0]    r_rootch;
    logic [EW-1:0] r_sp;
    logic [EW-1:0] r_comp;

    logic          r_ovalid;
    logic [1:0]    r_okind;
    logic [CW-1:0] r_ocomp;
    logic [VW-1:0] r_ofrom, r_oto, r_ocut;
    logic [EW-1:0] r_ocount;
    logic          r_obic, r_oovf, r_olast;

    logic          out_free;
    logic          out_load;
    logic          found;
    logic [VW-1:0] fw;
    logic [VW:0]   dm2;
    logic [EW-1:0] spm1;
    logic          can_push;
    logic [SW-1:0] clk_inc;
    logic          pop_hit;

    assign out_free = !r_ovalid || o_res.ready;
    assign out_load = out_free && ((r_state == S_POPW) || (r_state == S_DONE) ||
                                   ((r_state == S_CUT) && r_cut[r_cnt[VW-1:0]]));
    assign dm2      = r_depth - (VW+1)'(2);
    assign spm1     = r_sp - EW'(1);
    assign can_push = r_sp < EW'(NE);
    assign clk_inc  = r_clk_st + SW'(1);
    assign pop_hit  = (i_stk_rdata.from == r_v) && (i_stk_rdata.to == r_child);

    // Lowest neighbour at or above the scan position.
    always_comb begin
        found = 1'b0;
        fw    = '0;
        for (int i = NV - 1; i >= 0; i--) begin
            if (r_row[i] && (SW'(i) >= r_next)) begin
                found = 1'b1;
                fw    = VW'(i);
            end
        end
    end

    always_comb begin
        o_adj_we    = 1'b0;
        o_adj_waddr = r_a;
        o_adj_wdata = '0;
        o_adj_re    = 1'b0;
        o_adj_raddr = r_a;
        o_vtx_we    = 1'b0;
        o_vtx_waddr = r_v;
        o_vtx_wdata = '{disc: r_vdisc, low: r_vlow, par: r_vpar};
        o_vtx_re    = 1'b0;
        o_vtx_raddr = r_root[VW-1:0];
        o_frm_we    = 1'b0;
        o_frm_waddr = dm2[VW-1:0] + VW'(1);
        o_frm_wdata = '{vtx: r_v, nxt: r_next};
        o_frm_re    = 1'b0;
        o_frm_raddr = dm2[VW-1:0];
        o_stk_we    = 1'b0;
        o_stk_waddr = r_sp[CW-1:0];
        o_stk_wdata = '{from: r_v, to: r_w};
        o_stk_re    = 1'b0;
        o_stk_raddr = spm1[CW-1:0];
        unique case (r_state)
            S_CLR: begin
                o_adj_we    = 1'b1;
                o_adj_waddr = r_cnt[VW-1:0];
            end
            S_ADD1: begin
                o_adj_re = 1'b1;
            end
            S_ADD2: begin
                o_adj_we    = !i_adj_rdata[r_b] && (r_etotal != EW'(NE));
                o_adj_wdata = i_adj_rdata | (NV'(1) << r_b);
            end
            S_ADD3: begin
                o_adj_re    = 1'b1;
                o_adj_raddr = r_b;
            end
            S_ADD4: begin
                o_adj_we    = 1'b1;
                o_adj_waddr = r_b;
                o_adj_wdata = i_adj_rdata | (NV'(1) << r_a);
            end
            S_SCLR: begin
                o_vtx_we    = 1'b1;
                o_vtx_waddr = r_cnt[VW-1:0];
                o_vtx_wdata = '{disc: '0, low: '0, par: NO_PARENT};
            end
            S_ROOT: begin
                o_vtx_re = !r_root[VW];
            end
            S_ROOT_CHK: begin
                o_vtx_we    = r_present[r_root[VW-1:0]] && (i_vtx_rdata.disc == '0);
                o_vtx_waddr = r_root[VW-1:0];
                o_vtx_wdata = '{disc: clk_inc, low: clk_inc, par: NO_PARENT};
            end
            S_LOADROW: begin
                o_adj_re    = 1'b1;
                o_adj_raddr = r_v;
            end
            S_SCAN: begin
                o_vtx_re    = found;
                o_vtx_raddr = fw;
            end
            S_NB: begin
                if (i_vtx_rdata.disc == '0) begin
                    o_vtx_we    = 1'b1;
                    o_vtx_waddr = r_w;
                    o_vtx_wdata = '{disc: clk_inc, low: clk_inc, par: SW'(r_v)};
                    o_stk_we    = can_push;
                end else if ((i_vtx_rdata.disc < r_vdisc) && (SW'(r_w) != r_vpar)) begin
                    o_stk_we = can_push;
                end
            end
            S_DESC: begin
                o_vtx_we = 1'b1;
                o_frm_we = 1'b1;
            end
            S_RET: begin
                o_frm_re = (r_depth != (VW+1)'(1));
            end
            S_RET1: begin
                o_vtx_re    = 1'b1;
                o_vtx_raddr = i_frm_rdata.vtx;
            end
            S_POP: begin
                o_stk_re = (r_sp != '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_cnt     <= '0;
            r_present <= '0;
            r_etotal  <= '0;
            r_ovf     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_a   <= i_req.vertex_a;
                        r_b   <= i_req.vertex_b;
                        r_cnt <= '0;
                        case (i_req.req_type)
                            REQ_ADD: begin
                                if (i_req.vertex_a == i_req.vertex_b) begin
                                    r_present[i_req.vertex_a] <= 1'b1;
                                end else begin
                                    r_state <= S_ADD1;
                                end
                            end
                            REQ_RUN: r_state <= S_SCLR;
                            REQ_CLR: r_state <= S_CLR;
                            default: begin
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_present <= '0;
                    r_etotal  <= '0;
                    r_ovf     <= 1'b0;
                    r_cnt     <= r_cnt + (VW+1)'(1);
                    if (r_cnt[VW-1:0] == VW'(NV - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ADD1: r_state <= S_ADD2;
                S_ADD2: begin
                    if (i_adj_rdata[r_b]) begin
                        r_present[r_a] <= 1'b1;
                        r_present[r_b] <= 1'b1;
                        r_state        <= S_IDLE;
                    end else if (r_etotal == EW'(NE)) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_ADD3;
                    end
                end
                S_ADD3: r_state <= S_ADD4;
                S_ADD4: begin
                    r_present[r_a] <= 1'b1;
                    r_present[r_b] <= 1'b1;
                    r_etotal       <= r_etotal + EW'(1);
                    r_state        <= S_IDLE;
                end
                S_SCLR: begin
                    r_sp     <= '0;
                    r_cut    <= '0;
                    r_clk_st <= '0;
                    r_comp   <= '0;
                    r_root   <= '0;
                    r_cnt    <= r_cnt + (VW+1)'(1);
                    if (r_cnt[VW-1:0] == VW'(NV - 1)) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_cnt   <= '0;
                    r_state <= r_root[VW] ? S_CUT : S_ROOT_CHK;
                end
                S_ROOT_CHK: begin
                    if (r_present[r_root[VW-1:0]] && (i_vtx_rdata.disc == '0)) begin
                        r_clk_st <= clk_inc;
                        r_v      <= r_root[VW-1:0];
                        r_vdisc  <= clk_inc;
                        r_vlow   <= clk_inc;
                        r_vpar   <= NO_PARENT;
                        r_next   <= '0;
                        r_depth  <= (VW+1)'(1);
                        r_rootch <= '0;
                        r_state  <= S_LOADROW;
                    end else begin
                        r_root  <= r_root + (VW+1)'(1);
                        r_state <= S_ROOT;
                    end
                end
                S_LOADROW: r_state <= S_ROW;
                S_ROW: begin
                    r_row   <= i_adj_rdata;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (found) begin
                        r_w     <= fw;
                        r_next  <= SW'(fw) + SW'(1);
                        r_state <= S_NB;
                    end else begin
                        r_state <= S_RET;
                    end
                end
                S_NB: begin
                    if (i_vtx_rdata.disc == '0) begin
                        if (can_push) begin
                            r_sp <= r_sp + EW'(1);
                        end
                        if ((r_v == r_root[VW-1:0]) && (r_rootch != 2'd2)) begin
                            r_rootch <= r_rootch + 2'd1;
                        end
                        r_clk_st <= clk_inc;
                        r_state  <= S_DESC;
                    end else begin
                        if ((i_vtx_rdata.disc < r_vdisc) && (SW'(r_w) != r_vpar)) begin
                            if (can_push) begin
                                r_sp <= r_sp + EW'(1);
                            end
                            if (i_vtx_rdata.disc < r_vlow) begin
                                r_vlow <= i_vtx_rdata.disc;
                            end
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_DESC: begin
                    r_v     <= r_w;
                    r_vdisc <= r_clk_st;
                    r_vlow  <= r_clk_st;
                    r_vpar  <= SW'(r_v);
                    r_next  <= '0;
                    r_depth <= r_depth + (VW+1)'(1);
                    r_state <= S_LOADROW;
                end
                S_RET: begin
                    if (r_depth == (VW+1)'(1)) begin
                        if (r_rootch == 2'd2) begin
                            r_cut[r_root[VW-1:0]] <= 1'b1;
                        end
                        r_root  <= r_root + (VW+1)'(1);
                        r_state <= S_ROOT;
                    end else begin
                        r_depth <= r_depth - (VW+1)'(1);
                        r_child <= r_v;
                        r_clow  <= r_vlow;
                        r_state <= S_RET1;
                    end
                end
                S_RET1: begin
                    r_v     <= i_frm_rdata.vtx;
                    r_next  <= i_frm_rdata.nxt;
                    r_state <= S_RET2;
                end
                S_RET2: begin
                    r_vdisc <= i_vtx_rdata.disc;
                    r_vpar  <= i_vtx_rdata.par;
                    if (r_clow >= i_vtx_rdata.disc) begin
                        r_vlow  <= i_vtx_rdata.low;
                        r_state <= S_POP;
                    end else begin
                        r_vlow  <= (r_clow < i_vtx_rdata.low) ? r_clow : i_vtx_rdata.low;
                        r_state <= S_LOADROW;
                    end
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        r_comp <= r_comp + EW'(1);
                        if (r_v != r_root[VW-1:0]) begin
                            r_cut[r_v] <= 1'b1;
                        end
                        r_state <= S_LOADROW;
                    end else begin
                        r_sp    <= spm1;
                        r_state <= S_POPW;
                    end
                end
                S_POPW: begin
                    if (out_free) begin
                        r_okind  <= KIND_EDGE;
                        r_ocomp  <= r_comp[CW-1:0];
                        r_ofrom  <= i_stk_rdata.from;
                        r_oto    <= i_stk_rdata.to;
                        r_ocut   <= '0;
                        r_ocount <= '0;
                        r_obic   <= 1'b0;
                        r_oovf   <= 1'b0;
                        r_olast  <= 1'b0;
                        if (pop_hit) begin
                            r_comp <= r_comp + EW'(1);
                            if (r_v != r_root[VW-1:0]) begin
                                r_cut[r_v] <= 1'b1;
                            end
                            r_state <= S_LOADROW;
                        end else begin
                            r_state <= S_POP;
                        end
                    end
                end
                S_CUT: begin
                    if (out_free) begin
                        if (r_cut[r_cnt[VW-1:0]]) begin
                            r_okind  <= KIND_CUT;
                            r_ocomp  <= '0;
                            r_ofrom  <= '0;
                            r_oto    <= '0;
                            r_ocut   <= r_cnt[VW-1:0];
                            r_ocount <= '0;
                            r_obic   <= 1'b0;
                            r_oovf   <= 1'b0;
                            r_olast  <= 1'b0;
                        end
                        r_cnt <= r_cnt + (VW+1)'(1);
                        if (r_cnt[VW-1:0] == VW'(NV - 1)) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_okind  <= KIND_DONE;
                        r_ocomp  <= '0;
                        r_ofrom  <= '0;
                        r_oto    <= '0;
                        r_ocut   <= '0;
                        r_ocount <= r_comp;
                        r_obic   <= (r_comp == EW'(1));
                        r_oovf   <= r_ovf;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_res.valid           = r_ovalid;
    assign o_res.kind            = r_okind;
    assign o_res.component_index = r_ocomp;
    assign o_res.edge_from       = r_ofrom;
    assign o_res.edge_to         = r_oto;
    assign o_res.cut_vertex      = r_ocut;
    assign o_res.component_count = r_ocount;
    assign o_res.biconnected     = r_obic;
    assign o_res.overflow        = r_oovf;
    assign o_res.last            = r_olast;
endmodule

/* rtl/core/biconnected_components_finder.sv */
// Biconnected components finder. Add loads an undirected edge (a self loop only marks the
// vertex present; a duplicate or an edge past capacity is dropped); clear empties the graph.
// A run sweeps the search state, probes each root, follows neighbours depth first, returns
// and pops the edges of each closed component, then sends the cut list and the done beat;
// each step waits on a registered RAM read, and stalled beats slow it.
// Reset is synchronous, active low, and followed by a busy adjacency clearing pass.
module biconnected_components_finder import bcf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bcf_req_if.sink   i_req,
    bcf_res_if.source o_res
);
    logic          adj_we, adj_re, vtx_we, vtx_re, frm_we, frm_re, stk_we, stk_re;
    logic [VW-1:0] adj_waddr, adj_raddr, vtx_waddr, vtx_raddr, frm_waddr, frm_raddr;
    logic [CW-1:0] stk_waddr, stk_raddr;
    logic [NV-1:0] adj_wdata, adj_rdata;
    t_vtx          vtx_wdata, vtx_rdata;
    t_frame        frm_wdata, frm_rdata;
    t_edge         stk_wdata, stk_rdata;

    bcf_ram #(.WIDTH(NV), .DEPTH(NV)) u_adj_ram (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_re(adj_re), .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );

    bcf_ram #(.WIDTH($bits(t_vtx)), .DEPTH(NV)) u_vtx_ram (
        .i_clk(i_clk), .i_we(vtx_we), .i_waddr(vtx_waddr), .i_wdata(vtx_wdata),
        .i_re(vtx_re), .i_raddr(vtx_raddr), .o_rdata(vtx_rdata)
    );

    bcf_ram #(.WIDTH($bits(t_frame)), .DEPTH(NV)) u_frm_ram (
        .i_clk(i_clk), .i_we(frm_we), .i_waddr(frm_waddr), .i_wdata(frm_wdata),
        .i_re(frm_re), .i_raddr(frm_raddr), .o_rdata(frm_rdata)
    );

    bcf_ram #(.WIDTH($bits(t_edge)), .DEPTH(NE)) u_stk_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_re(stk_re), .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    bcf_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .o_res(o_res),
        .o_adj_we(adj_we), .o_adj_waddr(adj_waddr), .o_adj_wdata(adj_wdata),
        .o_adj_re(adj_re), .o_adj_raddr(adj_raddr), .i_adj_rdata(adj_rdata),
        .o_vtx_we(vtx_we), .o_vtx_waddr(vtx_waddr), .o_vtx_wdata(vtx_wdata),
        .o_vtx_re(vtx_re), .o_vtx_raddr(vtx_raddr), .i_vtx_rdata(vtx_rdata),
        .o_frm_we(frm_we), .o_frm_waddr(frm_waddr), .o_frm_wdata(frm_wdata),
        .o_frm_re(frm_re), .o_frm_raddr(frm_raddr), .i_frm_rdata(frm_rdata),
        .o_stk_we(stk_we), .o_stk_waddr(stk_waddr), .o_stk_wdata(stk_wdata),
        .o_stk_re(stk_re), .o_stk_raddr(stk_raddr), .i_stk_rdata(stk_rdata)
    );

    // While requests are taken, only the closing done beat of a run may still be waiting.
    a_idle_pending_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.ready && o_res.valid) |-> (o_res.last && o_res.kind == KIND_DONE))
        else $error("result pending while idle is not a done beat");

    // The clearing pass follows reset, so no request is taken in the next cycle.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req.ready)
        else $error("request taken during the post-reset clearing pass");

    // Only the done beat is marked last.
    a_last_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.last == (o_res.kind == KIND_DONE)))
        else $error("last flag disagrees with beat kind");
endmodule

/* tb/tb_biconnected_components_finder.sv */
// Self-checking testbench for biconnected_components_finder: random graphs are loaded,
// searched and cleared, and every result beat is checked against an in-bench predictor.
// Depends on bcf_pkg, bcf_req_if, bcf_res_if and the block itself.
`timescale 1ns / 1ps

module tb_biconnected_components_finder;
    import bcf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int RANDOM_ITEMS   = 450;

    // Request code that the block ignores.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]    kind;
        logic [CW-1:0] comp;
        logic [VW-1:0] efrom;
        logic [VW-1:0] eto;
        logic [VW-1:0] cut;
        logic [EW-1:0] count;
        logic          bic;
        logic          ovf;
        logic          last;
    } t_beat;

    class bcc_scoreboard;
        logic [NV-1:0] adj[NV];
        logic [NV-1:0] present;
        int            edges;
        bit            ovf;
        t_beat         awaited[$];
        int            errors;

        function new();
            foreach (adj[i]) adj[i] = '0;
            present = '0;
            edges   = 0;
            ovf     = 0;
            errors  = 0;
        endfunction

        function void push_beat(logic [1:0] k, int c, int f, int t, int cv, int n,
                                bit b, bit o, bit l);
            t_beat x;
            x.kind = k; x.comp = CW'(c); x.efrom = VW'(f); x.eto = VW'(t); x.cut = VW'(cv);
            x.count = EW'(n); x.bic = b; x.ovf = o; x.last = l;
            awaited.insert(awaited.size(), x);
        endfunction

        function void load_edge(int a, int b);
            if (a == b) begin
                present[a] = 1'b1;
            end else if (adj[a][b]) begin
                present[a] = 1'b1;
                present[b] = 1'b1;
            end else if (edges >= NE) begin
                ovf = 1;
            end else begin
                adj[a][b]  = 1'b1;
                adj[b][a]  = 1'b1;
                present[a] = 1'b1;
                present[b] = 1'b1;
                edges++;
            end
        endfunction

        // Iterative Tarjan search; components are emitted as they close.
        function void search();
            int disc[NV], low[NV], par[NV], fv[NV], fn[NV];
            int sf[NE], st[NE];
            int sp, stamp, comp, depth, kids, v, w, p, f, s;
            logic [NV-1:0] cuts;
            bit stop;
            sp = 0; stamp = 0; comp = 0; cuts = '0;
            for (int i = 0; i < NV; i++) begin
                disc[i] = 0; low[i] = 0; par[i] = NV;
            end
            for (int r = 0; r < NV; r++) begin
                if (!present[r] || disc[r] != 0) continue;
                kids = 0;
                stamp++;
                disc[r] = stamp; low[r] = stamp; par[r] = NV;
                fv[0] = r; fn[0] = 0; depth = 1;
                while (depth > 0) begin
                    v = fv[depth-1];
                    w = NV;
                    for (int i = fn[depth-1]; i < NV; i++)
                        if (adj[v][i]) begin
                            w = i;
                            break;
                        end
                    if (w < NV) begin
                        fn[depth-1] = w + 1;
                        if (disc[w] == 0) begin
                            if (sp < NE) begin sf[sp] = v; st[sp] = w; sp++; end
                            par[w] = v;
                            if (v == r) kids++;
                            stamp++;
                            disc[w] = stamp; low[w] = stamp;
                            if (depth < NV) begin
                                fv[depth] = w; fn[depth] = 0; depth++;
                            end
                        end else if (disc[w] < disc[v] && w != par[v]) begin
                            if (sp < NE) begin sf[sp] = v; st[sp] = w; sp++; end
                            if (disc[w] < low[v]) low[v] = disc[w];
                        end
                    end else begin
                        depth--;
                        if (depth > 0) begin
                            p = fv[depth-1];
                            if (low[v] >= disc[p]) begin
                                stop = 0;
                                while (sp > 0 && !stop) begin
                                    sp--;
                                    f = sf[sp]; s = st[sp];
                                    push_beat(KIND_EDGE, comp, f, s, 0, 0, 0, 0, 0);
                                    stop = (f == p && s == v);
                                end
                                comp++;
                                if (p != r) cuts[p] = 1'b1;
                            end else if (low[v] < low[p]) begin
                                low[p] = low[v];
                            end
                        end
                    end
                end
                if (kids >= 2) cuts[r] = 1'b1;
            end
            for (int i = 0; i < NV; i++)
                if (cuts[i]) push_beat(KIND_CUT, 0, 0, 0, i, 0, 0, 0, 0);
            push_beat(KIND_DONE, 0, 0, 0, 0, comp, comp == 1, ovf, 1);
        endfunction

        function void note_request(logic [1:0] req, logic [VW-1:0] a, logic [VW-1:0] b);
            case (req)
                REQ_ADD: load_edge(a, b);
                REQ_RUN: search();
                REQ_CLR: begin
                    foreach (adj[i]) adj[i] = '0;
                    present = '0;
                    edges   = 0;
                    ovf     = 0;
                end
                default: ;
            endcase
        endfunction

        task report(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(t_beat got);
            t_beat e;
            if (awaited.size() == 0) begin
                report("unexpected beat, kind", got.kind, -1);
                return;
            end
            e = awaited.pop_front();
            if (got.kind  !== e.kind)  report("kind", got.kind, e.kind);
            if (got.comp  !== e.comp)  report("component_index", got.comp, e.comp);
            if (got.efrom !== e.efrom) report("edge_from", got.efrom, e.efrom);
            if (got.eto   !== e.eto)   report("edge_to", got.eto, e.eto);
            if (got.cut   !== e.cut)   report("cut_vertex", got.cut, e.cut);
            if (got.count !== e.count) report("component_count", got.count, e.count);
            if (got.bic   !== e.bic)   report("biconnected", got.bic, e.bic);
            if (got.ovf   !== e.ovf)   report("overflow", got.ovf, e.ovf);
            if (got.last  !== e.last)  report("last", got.last, e.last);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bcf_req_if req_ch();
    bcf_res_if res_ch();

    biconnected_components_finder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bcc_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int items_sent     = 0;
    bit drained_once   = 1'b0;

    // Result side: check accepted beats and choose the next ready at random.
    always @(posedge i_clk) begin
        t_beat got;
        if (res_ch.valid && res_ch.ready) begin
            got.kind  = res_ch.kind;
            got.comp  = res_ch.component_index;
            got.efrom = res_ch.edge_from;
            got.eto   = res_ch.edge_to;
            got.cut   = res_ch.cut_vertex;
            got.count = res_ch.component_count;
            got.bic   = res_ch.biconnected;
            got.ovf   = res_ch.overflow;
            got.last  = res_ch.last;
            sb.check_result(got);
        end
        if (i_rst_n)
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        else
            res_ch.ready <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task set_phase();
        case ((items_sent * 4) / (RANDOM_ITEMS + 25))
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
    endtask

    // One request beat; valid stays high into the next call unless a gap is drawn.
    task send(logic [1:0] req, logic [VW-1:0] a, logic [VW-1:0] b);
        set_phase();
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= req;
        req_ch.vertex_a <= a;
        req_ch.vertex_b <= b;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(req, a, b);
        items_sent++;
    endtask

    task send_edge(int a, int b);
        send(REQ_ADD, a[VW-1:0], b[VW-1:0]);
    endtask

    task random_graph();
        int hi, n;
        hi = $urandom_range(15, 2);
        n  = ($urandom_range(9) == 0) ? $urandom_range(45, 33) : $urandom_range(14, 1);
        send(REQ_CLR, VW'($urandom), VW'($urandom));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0)
                send(REQ_UNUSED, VW'($urandom), VW'($urandom));
            else
                send_edge($urandom_range(hi), $urandom_range(hi));
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_ADD;
        req_ch.vertex_a <= '0;
        req_ch.vertex_b <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Triangle with a pendant edge, a self loop, a duplicate and a far edge.
        send_edge(0, 1);
        send_edge(1, 2);
        send_edge(2, 0);
        send_edge(2, 3);
        send_edge(5, 5);
        send_edge(1, 0);
        send_edge(15, 14);
        send_edge(3, 15);
        send(REQ_RUN, 4'hf, 4'hf);
        send(REQ_RUN, 4'h0, 4'h0);
        send(REQ_UNUSED, 4'ha, 4'h5);
        send(REQ_CLR, 4'h5, 4'ha);
        send(REQ_RUN, 4'h0, 4'h0);
        send_edge(7, 7);
        send(REQ_RUN, 4'h0, 4'h0);
        // A star: its centre is reached from the root at vertex 1 and has two children.
        send_edge(4, 9);
        send_edge(4, 12);
        send_edge(4, 1);
        send(REQ_RUN, 4'h0, 4'h0);

        while (items_sent < RANDOM_ITEMS) begin
            random_graph();
            if (!drained_once && items_sent > RANDOM_ITEMS / 2) begin
                drained_once = 1'b1;
                req_ch.valid <= 1'b0;
                while (sb.awaited.size() != 0) @(posedge i_clk);
            end
            send(REQ_RUN, VW'($urandom), VW'($urandom));
            if ($urandom_range(4) == 0) send(REQ_RUN, VW'($urandom), VW'($urandom));
        end
        req_ch.valid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
